// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SBGA_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SBGA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/sbga_pkg.sv =====
// Package for the shuffle bag group assigner: constants, field widths, state type.
`default_nettype none

package sbga_pkg;

   localparam int MAX_GROUPS_DEF    = 16;
   localparam int WORD_W            = 32;
   localparam int COUNT_W           = 5;
   localparam int LABEL_FIELD_W     = 4;
   localparam int TALLY_W           = 32;
   localparam int BAG_LEFT_W        = 5;
   localparam int RSP_FIELDS_W      = LABEL_FIELD_W + TALLY_W + BAG_LEFT_W;
   localparam int RSP_DATA_W        = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int TALLY_LSB         = LABEL_FIELD_W;
   localparam int BAG_LEFT_LSB      = LABEL_FIELD_W + TALLY_W;
   localparam logic [COUNT_W-1:0] GROUP_COUNT_RESET = COUNT_W'(10);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SLOT,
      ST_PICK,
      ST_UPDATE
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/shuffle_bag_group_assigner_core.sv =====
// Top level of the shuffle bag group assigner.
// Each request transaction carries a 32-bit random word and yields one response
// transaction: the group label drawn without replacement from a bag of labels,
// that group's saturating event tally, and the number of labels left in the bag.
// An empty bag is refilled with labels 0 to n-1, n being the group count register
// clamped to 1..MAX_GROUPS; a new count takes effect at the next refill. One request
// is in flight at a time; after acceptance it goes through the slot multiply, the bag
// read and compaction with the tally memory read, and the tally write-back, which
// waits until the response register is free and loads it. The request side is ready
// again in the cycle the response register loads, so a new request is taken only once
// the last response has loaded. Tallies clear at reset through per-entry valid bits.
`default_nettype none

module shuffle_bag_group_assigner_core import sbga_pkg::*; #(
   parameter int MAX_GROUPS = MAX_GROUPS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [WORD_W-1:0]     req_tdata,   // [31:0] random_word
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [3:0] group_label, [35:4] group_tally,
                                                   // [40:36] bag_left, rest zero
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [COUNT_W-1:0]    csr_data     // [4:0] group_count
);

   localparam int LW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int SW = $clog2(MAX_GROUPS + 1);

   state_type              state_ff, state_in;
   logic [WORD_W-1:0]      word_ff, word_in;
   logic [SW-1:0]          size_ff, size_in;
   logic [LW-1:0]          bag_ff [MAX_GROUPS];
   logic [LW-1:0]          bag_in [MAX_GROUPS];
   logic [LW-1:0]          slot_ff, slot_in;
   logic [LW-1:0]          label_ff, label_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [MAX_GROUPS-1:0]  tvalid_ff, tvalid_in;
   logic                   rd_valid_ff;
   logic [TALLY_W-1:0]     rd_data_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [TALLY_W-1:0]     tally_mem [MAX_GROUPS];

   logic [SW-1:0]          eff_count;
   logic [WORD_W+SW-1:0]   product;
   logic [LW-1:0]          pick_label;
   logic                   mem_rd_en;
   logic                   mem_wr_en;
   logic [TALLY_W-1:0]     tally_old;
   logic [TALLY_W-1:0]     tally_new;
   logic                   out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign product    = (WORD_W+SW)'(word_ff) * (WORD_W+SW)'(size_ff);
   assign pick_label = bag_ff[slot_ff];
   assign tally_old  = rd_valid_ff ? rd_data_ff : '0;
   assign tally_new  = (tally_old == '1) ? tally_old : tally_old + TALLY_W'(1);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if (count_ff == '0) begin
         eff_count = SW'(1);
      end else if (32'(count_ff) > 32'(MAX_GROUPS)) begin
         eff_count = SW'(MAX_GROUPS);
      end else begin
         eff_count = SW'(count_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      word_in      = word_ff;
      size_in      = size_ff;
      bag_in       = bag_ff;
      slot_in      = slot_ff;
      label_in     = label_ff;
      count_in     = count_ff;
      tvalid_in    = tvalid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_rd_en    = 1'b0;
      mem_wr_en    = 1'b0;

      if (csr_valid && csr_ready) begin
         count_in = csr_data;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               word_in  = req_tdata;
               state_in = ST_SLOT;
               if (size_ff == '0) begin
                  size_in = eff_count;
                  for (int i = 0; i < MAX_GROUPS; i++) begin
                     if (32'(i) < 32'(eff_count)) begin
                        bag_in[i] = LW'(i);
                     end
                  end
               end
            end
         end
         ST_SLOT: begin
            slot_in  = LW'(product[WORD_W+SW-1:WORD_W]);
            state_in = ST_PICK;
         end
         ST_PICK: begin
            label_in  = pick_label;
            mem_rd_en = 1'b1;
            size_in   = size_ff - SW'(1);
            for (int i = 0; i < MAX_GROUPS - 1; i++) begin
               if (32'(i) >= 32'(slot_ff)) begin
                  bag_in[i] = bag_ff[i + 1];
               end
            end
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) begin
               mem_wr_en           = 1'b1;
               tvalid_in[label_ff] = 1'b1;
               rsp_valid_in        = 1'b1;
               rsp_data_in         = '0;
               rsp_data_in[LABEL_FIELD_W-1:0]          = LABEL_FIELD_W'(label_ff);
               rsp_data_in[TALLY_LSB +: TALLY_W]       = tally_new;
               rsp_data_in[BAG_LEFT_LSB +: BAG_LEFT_W] = BAG_LEFT_W'(size_ff);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= '0;
         count_ff     <= GROUP_COUNT_RESET;
         tvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         count_ff     <= count_in;
         tvalid_ff    <= tvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      bag_ff      <= bag_in;
      slot_ff     <= slot_in;
      label_ff    <= label_in;
      rsp_data_ff <= rsp_data_in;
   end

   // tally memory: one synchronous read port, one write port
   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         rd_data_ff  <= tally_mem[pick_label];
         rd_valid_ff <= tvalid_ff[pick_label];
      end
      if (mem_wr_en) begin
         tally_mem[label_ff] <= tally_new;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sbga_checker.sv =====
// Port-level assertion checker for the shuffle bag group assigner, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module sbga_checker import sbga_pkg::*; #(
   parameter int MAX_GROUPS = MAX_GROUPS_DEF
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   `SBGA_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)
   `SBGA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `SBGA_ASSERT_IMPLY(a_bag_left_range, clock, reset, rsp_tvalid, 32'(rsp_tdata[BAG_LEFT_LSB +: BAG_LEFT_W]) < 32'(MAX_GROUPS))
   `SBGA_ASSERT_IMPLY(a_label_range, clock, reset, rsp_tvalid, (MAX_GROUPS > 16) || (32'(rsp_tdata[LABEL_FIELD_W-1:0]) < 32'(MAX_GROUPS)))

endmodule

bind shuffle_bag_group_assigner_core sbga_checker #(
   .MAX_GROUPS (MAX_GROUPS)
) u_sbga_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== test/tb_shuffle_bag_group_assigner_core.sv =====
// Self-checking testbench for shuffle_bag_group_assigner_core: predicted draws vs responses.
module tb_shuffle_bag_group_assigner_core;
   timeunit 1ns;
   timeprecision 1ps;

   import sbga_pkg::*;

   typedef struct packed {
      logic [LABEL_FIELD_W-1:0] label;
      logic [TALLY_W-1:0]       tally;
      logic [BAG_LEFT_W-1:0]    left;
   } draw_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [WORD_W-1:0]      req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [COUNT_W-1:0]     csr_data   = '0;

   // predictor state
   logic [LABEL_FIELD_W-1:0] bag_model [MAX_GROUPS_DEF];
   logic [BAG_LEFT_W-1:0]    bag_count;
   logic [TALLY_W-1:0]       tally_model [MAX_GROUPS_DEF];
   logic [COUNT_W-1:0]       group_count_model;

   draw_type expected_draws [$];
   int    mismatch_count  = 0;
   int    sender_idle_pct = 10;
   int    rsp_idle_pct    = 50;
   int    hold_request    = 0;
   int    rsp_hold        = 0;

   shuffle_bag_group_assigner_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      $display("ERROR at %0t ns: %s expected 0x%0h got 0x%0h", $time, what, want, got);
      mismatch_count++;
   endtask

   function automatic draw_type predict_draw(input logic [WORD_W-1:0] word);
      logic [63:0] product;
      int          n;
      int          slot;
      int          label;
      int          i;
      draw_type    d;
      if (bag_count == 0) begin
         n = group_count_model;
         if (n == 0) n = 1;
         if (n > MAX_GROUPS_DEF) n = MAX_GROUPS_DEF;
         for (i = 0; i < n; i++) bag_model[i] = i[LABEL_FIELD_W-1:0];
         bag_count = n[BAG_LEFT_W-1:0];
      end
      product = {32'd0, word} * {59'd0, bag_count};
      slot = int'(product[63:32]);
      if (slot >= bag_count) slot = bag_count - 1;
      label = bag_model[slot];
      for (i = slot; i + 1 < bag_count; i++) bag_model[i] = bag_model[i + 1];
      bag_count = bag_count - 1'b1;
      if (tally_model[label] != '1) tally_model[label] = tally_model[label] + 1'b1;
      d.label = label[LABEL_FIELD_W-1:0];
      d.tally = tally_model[label];
      d.left  = bag_count;
      return d;
   endfunction

   // response checker
   always @(posedge clock) begin : check_rsp
      draw_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_draws.size() == 0) begin
            report_mismatch("response with no pending draw", 64'd0, 64'(rsp_tdata));
         end else begin
            want = expected_draws.pop_front();
            if (rsp_tdata[LABEL_FIELD_W-1:0] !== want.label)
               report_mismatch("group_label", 64'(want.label),
                               64'(rsp_tdata[LABEL_FIELD_W-1:0]));
            if (rsp_tdata[TALLY_LSB +: TALLY_W] !== want.tally)
               report_mismatch("group_tally", 64'(want.tally),
                               64'(rsp_tdata[TALLY_LSB +: TALLY_W]));
            if (rsp_tdata[BAG_LEFT_LSB +: BAG_LEFT_W] !== want.left)
               report_mismatch("bag_left", 64'(want.left),
                               64'(rsp_tdata[BAG_LEFT_LSB +: BAG_LEFT_W]));
            if (rsp_tdata[RSP_DATA_W-1:RSP_FIELDS_W] !== '0)
               report_mismatch("pad bits", 64'd0,
                               64'(rsp_tdata[RSP_DATA_W-1:RSP_FIELDS_W]));
         end
      end
   end

   // receiver: random stalls plus long hold-offs on request
   always @(negedge clock) begin
      if (hold_request > 0) begin
         rsp_hold = hold_request;
         hold_request = 0;
      end
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // called at a falling edge; returns at a falling edge with tvalid still high
   task automatic send_word(input logic [WORD_W-1:0] word);
      draw_type pending;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending = predict_draw(word);
      expected_draws = {expected_draws, pending};
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_draws.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_group_count(input logic [COUNT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      group_count_model = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return WORD_W'($urandom_range(0, 255));
         3:       return ~WORD_W'($urandom_range(0, 255));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [COUNT_W-1:0] pick_count();
      case ($urandom_range(0, 9))
         0:       return 5'd0;
         1:       return 5'd1;
         2:       return 5'd16;
         3:       return 5'd31;
         4:       return COUNT_W'($urandom_range(17, 30));
         default: return COUNT_W'($urandom_range(1, 16));
      endcase
   endfunction

   // default count of ten: a full bag, then refill
   task automatic test_directed_draws();
      logic [WORD_W-1:0] words [12];
      int i;
      words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h0000_0001, 32'hFFFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA,
                32'h1999_9999, 32'hE666_6666, 32'h0000_0000, 32'hFFFF_FFFF};
      for (i = 0; i < 12; i++) send_word(words[i]);
   endtask

   // count writes of zero, a saturating value, one and sixteen, all with labels still in the bag
   task automatic test_count_extremes();
      wait_idle();
      write_group_count(5'd0);
      send_word('1);
      send_word('0);
      wait_idle();
      write_group_count(5'd31);
      send_word('1);
      wait_idle();
      write_group_count(5'd1);
      send_word('0);
      wait_idle();
      write_group_count(5'd16);
      send_word(32'h8000_0000);
      send_word('1);
      send_word(32'h0000_0001);
   endtask

   // long receiver hold-off with back-to-back requests
   task automatic test_input_stall();
      int i;
      wait_idle();
      sender_idle_pct = 0;
      @(posedge clock);
      hold_request = 400;
      @(negedge clock);
      for (i = 0; i < 24; i++) send_word(pick_word());
   endtask

   task automatic test_random_stream(input int count, input int s_pct, input int r_pct);
      int i;
      sender_idle_pct = s_pct;
      rsp_idle_pct    = r_pct;
      for (i = 0; i < count; i++) begin
         if ($urandom_range(0, 69) == 0) begin
            wait_idle();
            write_group_count(pick_count());
         end
         send_word(pick_word());
      end
   endtask

   initial begin
      for (int i = 0; i < MAX_GROUPS_DEF; i++) begin
         bag_model[i]   = '0;
         tally_model[i] = '0;
      end
      bag_count         = '0;
      group_count_model = GROUP_COUNT_RESET;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      test_directed_draws();
      test_count_extremes();
      test_input_stall();
      test_random_stream(560, 10, 50);
      test_random_stream(560, 50, 10);
      test_random_stream(560, 0, 0);
      wait_idle();
      if (mismatch_count == 0 && expected_draws.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== shuffle_bag_group_assigner_core.f =====
+incdir+rtl
rtl/sbga_pkg.sv
rtl/shuffle_bag_group_assigner_core.sv
rtl/sbga_checker.sv
test/tb_shuffle_bag_group_assigner_core.sv
